FILE: hdl/slr_pkg.sv
package slr_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [0:0] {
    LIM_MC     = 1'b0,
    LIM_MINMOD = 1'b1
  } limiter_mode_e;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

FILE: hdl/slr_queue.sv
module slr_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output slr_pkg::queue_stat_t stat_o
);
  import slr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hdl/slr_front.sv
module slr_front #(
  parameter int unsigned W = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [W-1:0]         sample_i,
  input  logic                 line_start_i,
  input  slr_pkg::queue_stat_t stat_i,
  output logic                 push_o,
  output logic [4*W+2:0]       entry_o
);
  import slr_pkg::*;

  logic [W-1:0]        older_q, middle_q;
  logic [1:0]          fill_q, fill_d, fill_eff;
  logic                accept;
  logic signed [W:0]   back_diff, fwd_diff, central;
  logic [W-1:0]        dc;
  logic                same_sign;

  assign in_ready_o = !stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign fill_eff   = line_start_i ? 2'd0 : fill_q;
  assign push_o     = accept && (fill_eff == 2'd2);

  assign back_diff = $signed({middle_q[W-1], middle_q}) - $signed({older_q[W-1], older_q});
  assign fwd_diff  = $signed({sample_i[W-1], sample_i}) - $signed({middle_q[W-1], middle_q});
  assign central   = $signed({sample_i[W-1], sample_i}) - $signed({older_q[W-1], older_q});
  // floor halving of the central difference always fits W bits
  assign dc        = central[W:1];

  assign same_sign = (!back_diff[W] && |back_diff && !fwd_diff[W] && |fwd_diff)
                  || (back_diff[W] && fwd_diff[W]);

  // entry: middle, back, fwd, dc, same_sign from the lowest bit up
  assign entry_o = {same_sign, dc, fwd_diff, back_diff, middle_q};

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      fill_d = (fill_eff == 2'd2) ? 2'd2 : fill_eff + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      older_q  <= middle_q;
      middle_q <= sample_i;
    end
  end

endmodule

FILE: hdl/slr_back.sv
module slr_back #(
  parameter int unsigned W = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slr_pkg::limiter_mode_e mode_i,
  input  slr_pkg::queue_stat_t   stat_i,
  input  logic [4*W+2:0]         entry_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [W-1:0]           left_o,
  output logic [W-1:0]           right_o,
  output logic [W-1:0]           slope_o
);
  import slr_pkg::*;

  function automatic logic [W+1:0] mag(input logic signed [W+1:0] x);
    logic [W+1:0] r;
    r = x[W+1] ? -x : x;
    return r;
  endfunction

  function automatic logic [W-1:0] sat(input logic signed [W+2:0] x);
    logic [W-1:0] r;
    if (&x[W+2:W-1] || ~|x[W+2:W-1]) begin
      r = x[W-1:0];
    end else begin
      r = x[W+2] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  logic [W-1:0]        e_mid, e_dc;
  logic signed [W:0]   e_back, e_fwd;
  logic                e_same;
  logic signed [W+1:0] dm, dp, dcx, bx, fx, sl_d;
  logic [W+1:0]        m_dm, m_dp, m_dc, m_b, m_f;

  logic                a_valid_q, out_valid_q;
  logic                a_en, b_en;
  logic signed [W+1:0] sl_q;
  logic [W-1:0]        mid_q;
  logic signed [W+2:0] h, mid_x, left_x, right_x;

  assign {e_same, e_dc, e_fwd, e_back, e_mid} = entry_i;

  assign b_en  = !out_valid_q || out_ready_i;
  assign a_en  = !a_valid_q || b_en;
  assign pop_o = a_en && !stat_i.empty;

  assign dm   = {e_back, 1'b0};
  assign dp   = {e_fwd, 1'b0};
  assign dcx  = {{2{e_dc[W-1]}}, e_dc};
  assign bx   = {e_back[W], e_back};
  assign fx   = {e_fwd[W], e_fwd};
  assign m_dm = mag(dm);
  assign m_dp = mag(dp);
  assign m_dc = mag(dcx);
  assign m_b  = mag(bx);
  assign m_f  = mag(fx);

  always_comb begin
    sl_d = '0;
    if (e_same) begin
      case (mode_i)
        LIM_MC: begin
          if (m_dm < m_dp && m_dm < m_dc) begin
            sl_d = dm;
          end else if (m_dp < m_dc) begin
            sl_d = dp;
          end else begin
            sl_d = dcx;
          end
        end
        LIM_MINMOD: begin
          sl_d = (m_b < m_f) ? bx : fx;
        end
        default: begin
          sl_d = '0;
        end
      endcase
    end
  end

  // faces use half of the unsaturated slope
  assign h       = $signed({sl_q[W+1], sl_q}) >>> 1;
  assign mid_x   = {{3{mid_q[W-1]}}, mid_q};
  assign left_x  = mid_x - h;
  assign right_x = mid_x + h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_q <= !stat_i.empty;
      end
      if (b_en) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sl_q  <= sl_d;
      mid_q <= e_mid;
    end
    if (b_en && a_valid_q) begin
      left_o  <= sat(left_x);
      right_o <= sat(right_x);
      slope_o <= sat({sl_q[W+1], sl_q});
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/slope_limited_linear_reconstruction.sv
// Slope-limited linear reconstruction along one grid line. Samples are signed
// fixed point (Q16.16 at the default width) and enter on the slave stream with
// tuser high on the first cell of a line; the first two cells of every line give
// no result, every later cell gives one transaction on the master stream holding
// the left face, right face and limited slope of the previous cell, each
// saturated. The config channel selects monotonized central (0, after reset) or
// minmod (1) and may be written only while no transaction is in flight. One
// sample per cycle is taken and one result per cycle is delivered in steady
// state while the master stream is ready; the window and differences, the
// limiter and the face adders each hold one register stage, with a two-entry
// queue between the window and the limiter that absorbs stalls.
module slope_limited_linear_reconstruction #(
  parameter int unsigned SAMPLE_WIDTH = slr_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // sample
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata_i,
  // line_start
  input  logic [0:0]                            s_axis_tuser_i,
  // left_face, right_face, slope
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [0:0]                            cfg_data_i
);
  import slr_pkg::*;

  localparam int unsigned W         = SAMPLE_WIDTH;
  localparam int unsigned ENTRY_W   = 4 * W + 3;
  localparam int unsigned OUT_TDATA = ((3 * W + 7) / 8) * 8;

  limiter_mode_e       mode_q;
  queue_stat_t         qstat;
  logic                push, pop;
  logic [ENTRY_W-1:0]  wentry, rentry;
  logic [W-1:0]        left_face, right_face, slope;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= LIM_MC;
    end else if (cfg_valid_i) begin
      mode_q <= limiter_mode_e'(cfg_data_i[0]);
    end
  end

  slr_front #(.W(W)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .sample_i     (s_axis_tdata_i[W-1:0]),
    .line_start_i (s_axis_tuser_i[0]),
    .stat_i       (qstat),
    .push_o       (push),
    .entry_o      (wentry)
  );

  slr_queue #(.DATA_W(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .pop_i   (pop),
    .rdata_o (rentry),
    .stat_o  (qstat)
  );

  slr_back #(.W(W)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .stat_i      (qstat),
    .entry_i     (rentry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .left_o      (left_face),
    .right_o     (right_face),
    .slope_o     (slope)
  );

  assign m_axis_tdata_o = OUT_TDATA'({slope, right_face, left_face});

  // the window never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !qstat.full)
    else $error("push into full queue");

  // a line start never yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i[0]) |-> !push)
    else $error("result on line start");

  // nothing is pending right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid_o && qstat.empty)
    else $error("state not cleared by reset");

endmodule
